>>> hdl/ssi_pkg.sv
// shared types and constants for the sparse spike synaptic integrator
// no dependencies; every other file refers to this package by scoped names
`timescale 1ns / 1ps

package ssi_pkg;

  // active list of spiking sources
  localparam int LIST_DEPTH = 256;
  localparam int LIST_W     = 8;
  localparam int CNT_W      = 9;

  // config port: two 32-bit registers at byte offsets 0 and 4
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [8:0] SOURCE_COUNT_RST = 9'd256;
  localparam logic       USE_EFFICACY_RST = 1'b1;

  // arithmetic: weight q3.12 times efficacy q1.15 gives q.27, summed over the list
  localparam int VAL_W      = 16;
  localparam int PROD_W     = 32;
  localparam int SUM_W      = PROD_W + LIST_W;
  localparam int COND_W     = 31;
  localparam int ROUND_SHIFT = 15;
  localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (ROUND_SHIFT - 1);
  localparam logic [COND_W-1:0] COND_MAX = '1;

  typedef enum logic [1:0] {
    CMD_WEIGHT    = 2'd0,
    CMD_EFFICACY  = 2'd1,
    CMD_SPIKE     = 2'd2,
    CMD_INTEGRATE = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_ROUND,
    ST_WRITE
  } state_t;

  typedef enum logic {
    REG_SOURCE_COUNT = 1'b0,
    REG_USE_EFFICACY = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [8:0] source_count;
    logic       use_efficacy;
  } cfg_t;

endpackage

>>> hdl/ssi_if.sv
// valid/ready channel interfaces for the request and result streams
// depends on ssi_pkg for the command type
`timescale 1ns / 1ps

interface ssi_in_if;
  logic               valid;
  logic               ready;
  ssi_pkg::cmd_t      cmd;
  logic [7:0]         target_index;
  logic [7:0]         source_index;
  logic signed [15:0] weight_value;
  logic [15:0]        efficacy_value;
  logic               spike_bit;
  logic               accumulate;

  modport source (
    output valid, cmd, target_index, source_index, weight_value,
           efficacy_value, spike_bit, accumulate,
    input  ready
  );
  modport sink (
    input  valid, cmd, target_index, source_index, weight_value,
           efficacy_value, spike_bit, accumulate,
    output ready
  );
endinterface

interface ssi_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_target;
  logic [30:0] conductance;

  modport source (
    output valid, out_target, conductance,
    input  ready
  );
  modport sink (
    input  valid, out_target, conductance,
    output ready
  );
endinterface

>>> hdl/ssi_cfg.sv
// apb-style register block: source_count and use_efficacy
// depends on ssi_pkg for the register index codes and the cfg_t struct
`timescale 1ns / 1ps

module ssi_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ssi_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [ssi_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [ssi_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready,
  output ssi_pkg::cfg_t                     cfg
);

  logic [8:0]        source_count_r;
  logic              use_efficacy_r;
  logic              wr_en;
  ssi_pkg::reg_idx_t reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = ssi_pkg::reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      source_count_r <= ssi_pkg::SOURCE_COUNT_RST;
      use_efficacy_r <= ssi_pkg::USE_EFFICACY_RST;
    end else if (wr_en) begin
      case (reg_idx)
        ssi_pkg::REG_SOURCE_COUNT: source_count_r <= pwdata[8:0];
        ssi_pkg::REG_USE_EFFICACY: use_efficacy_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      ssi_pkg::REG_SOURCE_COUNT: prdata = {23'd0, source_count_r};
      ssi_pkg::REG_USE_EFFICACY: prdata = {31'd0, use_efficacy_r};
      default:                   prdata = '0;
    endcase
  end

  assign cfg.source_count = source_count_r;
  assign cfg.use_efficacy = use_efficacy_r;

endmodule

>>> hdl/sparse_spike_synaptic_integrator.sv
// top level: spike-driven sparse synaptic integration over on-chip stores
// depends on ssi_pkg, ssi_in_if / ssi_out_if and ssi_cfg
//
//   channel   direction  handshake        carries
//   in_ch     sink       valid/ready      cmd, target/source index, weight, efficacy, spike, acc
//   out_ch    source     valid/ready      out_target, conductance
//   apb       slave      psel/penable     source_count (0x0), use_efficacy (0x4)
//
// weight, efficacy and spike loads are written in the cycle they are accepted
// an integrate request holds off the input until the walk, round and write-back are done;
// its result becomes valid in the same cycle that the input is ready again
// the walk issues one active-list read per cycle into a
// list -> weight/efficacy -> multiply -> sum pipeline, then rounds and writes back
// after reset the conductance store is cleared one entry per cycle
// before the first request is taken; loads proceed while a result waits on out_ch,
// an integrate stalls in write-back until the waiting result is taken
`timescale 1ns / 1ps

module sparse_spike_synaptic_integrator #(
  parameter int MAX_SOURCES = 256,
  parameter int MAX_TARGETS = 256
) (
  input  logic                              clk,
  input  logic                              rst_n,
  ssi_in_if.sink                            in_ch,
  ssi_out_if.source                         out_ch,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ssi_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [ssi_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [ssi_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready
);

  localparam int SRC_W   = $clog2(MAX_SOURCES);
  localparam int TGT_W   = $clog2(MAX_TARGETS);
  localparam int WDEPTH  = MAX_SOURCES * MAX_TARGETS;
  localparam int WADDR_W = $clog2(WDEPTH);
  localparam int VAL_W   = ssi_pkg::VAL_W;
  localparam int PROD_W  = ssi_pkg::PROD_W;
  localparam int SUM_W   = ssi_pkg::SUM_W;
  localparam int COND_W  = ssi_pkg::COND_W;
  localparam int LIST_W  = ssi_pkg::LIST_W;
  localparam int CNT_W   = ssi_pkg::CNT_W;

  ssi_pkg::state_t state_r, state_nxt;
  ssi_pkg::cfg_t   cfg;

  logic                     in_ready;
  logic                     in_acc;
  logic                     clr_we;
  logic [TGT_W-1:0]         clr_idx_r;

  // request decode
  logic                     tgt_ok, src_ok, src_lim_ok;
  logic                     w_we, e_we, l_we, spike_acc, start_int;
  logic [CNT_W-1:0]         active_count_r, cnt_base;
  logic                     spike_ok;

  // stores
  logic [VAL_W-1:0]         weight_mem [WDEPTH];
  logic [VAL_W-1:0]         eff_mem [MAX_SOURCES];
  logic [LIST_W-1:0]        list_mem [ssi_pkg::LIST_DEPTH];
  logic [COND_W-1:0]        cond_mem [MAX_TARGETS];
  logic [WADDR_W-1:0]       w_wr_addr, w_rd_addr, row_base_r;
  logic [VAL_W-1:0]         w_q_r, e_q_r;
  logic [LIST_W-1:0]        list_q_r;
  logic [COND_W-1:0]        cond_q_r;
  logic                     cond_we;
  logic [TGT_W-1:0]         cond_wr_addr;
  logic [COND_W-1:0]        cond_wr_data;

  // integrate datapath
  logic [7:0]               tgt8_r;
  logic                     acc_r;
  logic [CNT_W-1:0]         k_r;
  logic                     issue, walk_done;
  logic                     p1_v_r, p2_v_r, p3_v_r;
  logic signed [VAL_W-1:0]  w_s;
  logic signed [VAL_W:0]    e_s;
  logic signed [PROD_W:0]   mul;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [SUM_W-1:0]  sum_r;
  logic [SUM_W-1:0]         sum_rnd;
  logic [COND_W-1:0]        contrib_r, contrib_nxt;
  logic [COND_W:0]          total;
  logic [COND_W-1:0]        cond_new;
  logic                     out_free, wr_done;

  logic                     out_valid_r;
  logic [7:0]               out_target_r;
  logic [COND_W-1:0]        out_cond_r;

  ssi_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign in_ready    = (state_r == ssi_pkg::ST_IDLE);
  assign in_ch.ready = in_ready;
  assign in_acc      = in_ch.valid && in_ready;

  // request decode
  always_comb begin
    tgt_ok     = 32'(in_ch.target_index) < MAX_TARGETS;
    src_ok     = 32'(in_ch.source_index) < MAX_SOURCES;
    src_lim_ok = src_ok && ({1'b0, in_ch.source_index} < cfg.source_count);
    w_we       = in_acc && (in_ch.cmd == ssi_pkg::CMD_WEIGHT) && tgt_ok && src_ok;
    e_we       = in_acc && (in_ch.cmd == ssi_pkg::CMD_EFFICACY) && src_ok;
    spike_acc  = in_acc && (in_ch.cmd == ssi_pkg::CMD_SPIKE);
    start_int  = in_acc && (in_ch.cmd == ssi_pkg::CMD_INTEGRATE) && tgt_ok;
    // source zero opens a fresh list before the append
    cnt_base   = (in_ch.source_index == '0) ? '0 : active_count_r;
    spike_ok   = in_ch.spike_bit && src_lim_ok && !cnt_base[CNT_W-1];
    l_we       = spike_acc && spike_ok;
    w_wr_addr  = WADDR_W'(32'(in_ch.target_index) * MAX_SOURCES
                          + 32'(in_ch.source_index));
  end

  // walk control
  assign issue     = (state_r == ssi_pkg::ST_WALK) && (k_r < active_count_r);
  assign walk_done = (state_r == ssi_pkg::ST_WALK) && (k_r == active_count_r)
                     && !p1_v_r && !p2_v_r && !p3_v_r;
  assign out_free  = !out_valid_r || out_ch.ready;
  assign wr_done   = (state_r == ssi_pkg::ST_WRITE) && out_free;

  always_comb begin
    state_nxt = state_r;
    clr_we    = 1'b0;
    case (state_r)
      ssi_pkg::ST_CLEAR: begin
        clr_we = 1'b1;
        if (clr_idx_r == TGT_W'(MAX_TARGETS - 1)) state_nxt = ssi_pkg::ST_IDLE;
      end
      ssi_pkg::ST_IDLE: begin
        if (start_int) state_nxt = ssi_pkg::ST_WALK;
      end
      ssi_pkg::ST_WALK: begin
        if (walk_done) state_nxt = ssi_pkg::ST_ROUND;
      end
      ssi_pkg::ST_ROUND: begin
        state_nxt = ssi_pkg::ST_WRITE;
      end
      ssi_pkg::ST_WRITE: begin
        if (out_free) state_nxt = ssi_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = ssi_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ssi_pkg::ST_CLEAR;
      clr_idx_r      <= '0;
      active_count_r <= '0;
      k_r            <= '0;
      p1_v_r         <= 1'b0;
      p2_v_r         <= 1'b0;
      p3_v_r         <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (clr_we) clr_idx_r <= clr_idx_r + 1'b1;
      if (spike_acc) active_count_r <= cnt_base + CNT_W'(spike_ok);
      if (start_int) begin
        k_r <= '0;
      end else if (issue) begin
        k_r <= k_r + 1'b1;
      end
      p1_v_r <= issue;
      p2_v_r <= p1_v_r;
      p3_v_r <= p2_v_r;
      if (wr_done) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // stores, all with a registered read port
  assign w_rd_addr = row_base_r + WADDR_W'(list_q_r);

  always_ff @(posedge clk) begin
    if (w_we) weight_mem[w_wr_addr] <= in_ch.weight_value;
    w_q_r <= weight_mem[w_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (e_we) eff_mem[SRC_W'(in_ch.source_index)] <= in_ch.efficacy_value;
    e_q_r <= eff_mem[SRC_W'(list_q_r)];
  end

  always_ff @(posedge clk) begin
    if (l_we) list_mem[cnt_base[LIST_W-1:0]] <= in_ch.source_index;
    list_q_r <= list_mem[k_r[LIST_W-1:0]];
  end

  assign cond_we      = clr_we || wr_done;
  assign cond_wr_addr = clr_we ? clr_idx_r : TGT_W'(tgt8_r);
  assign cond_wr_data = clr_we ? '0 : cond_new;

  always_ff @(posedge clk) begin
    if (cond_we) cond_mem[cond_wr_addr] <= cond_wr_data;
    cond_q_r <= cond_mem[TGT_W'(tgt8_r)];
  end

  // multiply and sum
  assign w_s = w_q_r;
  assign e_s = {1'b0, e_q_r};
  assign mul = w_s * e_s;

  // clamp at zero, round q.27 to q.12 half up when efficacy is on
  assign sum_rnd = sum_r + ssi_pkg::ROUND_HALF;
  always_comb begin
    if (sum_r[SUM_W-1] || sum_r == '0) begin
      contrib_nxt = '0;
    end else if (cfg.use_efficacy) begin
      contrib_nxt = COND_W'(sum_rnd >> ssi_pkg::ROUND_SHIFT);
    end else begin
      contrib_nxt = COND_W'(sum_r);
    end
  end

  assign total    = acc_r ? ({1'b0, cond_q_r} + {1'b0, contrib_r}) : {1'b0, contrib_r};
  assign cond_new = total[COND_W] ? ssi_pkg::COND_MAX : total[COND_W-1:0];

  always_ff @(posedge clk) begin
    if (start_int) begin
      tgt8_r     <= in_ch.target_index;
      acc_r      <= in_ch.accumulate;
      row_base_r <= WADDR_W'(32'(in_ch.target_index) * MAX_SOURCES);
      sum_r      <= '0;
    end else if (p3_v_r) begin
      sum_r <= sum_r + SUM_W'(prod_r);
    end
    if (p2_v_r) begin
      prod_r <= cfg.use_efficacy ? mul[PROD_W-1:0] : PROD_W'(w_s);
    end
    if (state_r == ssi_pkg::ST_ROUND) contrib_r <= contrib_nxt;
    if (wr_done) begin
      out_target_r <= tgt8_r;
      out_cond_r   <= cond_new;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_target  = out_target_r;
  assign out_ch.conductance = out_cond_r;

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    active_count_r <= CNT_W'(ssi_pkg::LIST_DEPTH))
    else $error("active count beyond list depth");

  a_pipe_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (p1_v_r || p2_v_r || p3_v_r) |-> state_r == ssi_pkg::ST_WALK)
    else $error("walk pipeline busy outside the walk");

  a_walk_index: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ssi_pkg::ST_WALK |=> (state_r != ssi_pkg::ST_WALK
                                    || k_r <= active_count_r))
    else $error("walk index ran past the active list");

endmodule
